[design/spd_pkg.sv]
// Package with shared types, header constants and the length decoder of the packet deframer.
package spd_pkg;

  localparam logic [7:0] HDR_BYTE0 = 8'h73;  // 's'
  localparam logic [7:0] HDR_BYTE1 = 8'h6E;  // 'n'
  localparam logic [7:0] HDR_BYTE2 = 8'h70;  // 'p'

  // Sum of the three header bytes, the starting value of the packet checksum.
  localparam logic [15:0] HDR_SUM = 16'(HDR_BYTE0) + 16'(HDR_BYTE1) + 16'(HDR_BYTE2);

  localparam logic [0:0] KIND_DATA = 1'b0;
  localparam logic [0:0] KIND_END  = 1'b1;

  localparam logic [0:0] STATUS_GOOD     = 1'b0;
  localparam logic [0:0] STATUS_MISMATCH = 1'b1;

  typedef struct packed {
    logic [0:0]  item_kind;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic [7:0]  packet_type;
    logic [7:0]  reg_address;
    logic [5:0]  payload_length;
    logic [0:0]  status;
    logic [15:0] computed_sum;
  } spd_result_t;

  // Payload length from the type byte: no data gives 0, a single register
  // gives 4 bytes, a batch gives 4 bytes per register in bits 5..2.
  function automatic logic [5:0] spd_decode_length(input logic [7:0] t);
    logic [5:0] len;
    if (!t[7]) begin
      len = 6'd0;
    end else if (!t[6]) begin
      len = 6'd4;
    end else begin
      len = {t[5:2], 2'b00};
    end
    return len;
  endfunction

endpackage

[design/spd_in_if.sv]
// Input channel interface: one received byte per item.
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/spd_out_if.sv]
// Result channel interface: payload byte items and end-of-packet items.
interface spd_out_if;
  logic        valid;
  logic        ready;
  logic [0:0]  item_kind;
  logic [7:0]  data_byte;
  logic [5:0]  byte_index;
  logic [7:0]  packet_type;
  logic [7:0]  reg_address;
  logic [5:0]  payload_length;
  logic [0:0]  status;
  logic [15:0] computed_sum;

  modport source (output valid, output item_kind, output data_byte, output byte_index,
                  output packet_type, output reg_address, output payload_length,
                  output status, output computed_sum, input ready);
  modport sink   (input valid, input item_kind, input data_byte, input byte_index,
                  input packet_type, input reg_address, input payload_length,
                  input status, input computed_sum, output ready);
endinterface

[design/spd_core.sv]
// Framing state machine, checksum adder and result register of the packet deframer.
module spd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  output logic                res_valid,
  input  logic                res_ready,
  output spd_pkg::spd_result_t res_data
);
  import spd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_GOT_S, PH_GOT_SN, PH_TYPE, PH_ADDR, PH_DATA, PH_CK_HI, PH_CK_LO
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_type_r, held_type_nxt;
  logic [7:0]  held_addr_r, held_addr_nxt;
  logic [5:0]  exp_len_r, exp_len_nxt;
  logic [5:0]  taken_r, taken_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  ck_hi_r, ck_hi_nxt;
  logic        res_valid_r, res_valid_nxt;
  spd_result_t res_r, res_nxt;

  logic        in_fire;
  logic        emit;
  logic [15:0] sum_plus;
  logic [15:0] rx_sum;

  // The result register frees up when it is empty or being drained this cycle.
  assign in_ready = !res_valid_r || res_ready;
  assign in_fire  = in_valid && in_ready;
  assign sum_plus = sum_r + 16'(in_byte);
  assign rx_sum   = {ck_hi_r, in_byte};

  always_comb begin
    phase_nxt     = phase_r;
    held_type_nxt = held_type_r;
    held_addr_nxt = held_addr_r;
    exp_len_nxt   = exp_len_r;
    taken_nxt     = taken_r;
    sum_nxt       = sum_r;
    ck_hi_nxt     = ck_hi_r;
    emit          = 1'b0;
    res_nxt       = res_r;
    if (in_fire) begin
      case (phase_r)
        PH_HUNT: begin
          phase_nxt = (in_byte == HDR_BYTE0) ? PH_GOT_S : PH_HUNT;
        end
        PH_GOT_S: begin
          if (in_byte == HDR_BYTE1) begin
            phase_nxt = PH_GOT_SN;
          end else begin
            phase_nxt = (in_byte == HDR_BYTE0) ? PH_GOT_S : PH_HUNT;
          end
        end
        PH_GOT_SN: begin
          if (in_byte == HDR_BYTE2) begin
            phase_nxt = PH_TYPE;
            sum_nxt   = HDR_SUM;
          end else begin
            phase_nxt = (in_byte == HDR_BYTE0) ? PH_GOT_S : PH_HUNT;
          end
        end
        PH_TYPE: begin
          held_type_nxt = in_byte;
          exp_len_nxt   = spd_decode_length(in_byte);
          taken_nxt     = 6'd0;
          sum_nxt       = sum_plus;
          phase_nxt     = PH_ADDR;
        end
        PH_ADDR: begin
          held_addr_nxt = in_byte;
          sum_nxt       = sum_plus;
          phase_nxt     = (exp_len_r == 6'd0) ? PH_CK_HI : PH_DATA;
        end
        PH_DATA: begin
          sum_nxt                = sum_plus;
          emit                   = 1'b1;
          res_nxt.item_kind      = KIND_DATA;
          res_nxt.data_byte      = in_byte;
          res_nxt.byte_index     = taken_r;
          res_nxt.packet_type    = held_type_r;
          res_nxt.reg_address    = held_addr_r;
          res_nxt.payload_length = exp_len_r;
          res_nxt.status         = STATUS_GOOD;
          res_nxt.computed_sum   = sum_plus;
          taken_nxt              = taken_r + 6'd1;
          if (taken_nxt >= exp_len_r) begin
            phase_nxt = PH_CK_HI;
          end
        end
        PH_CK_HI: begin
          ck_hi_nxt = in_byte;
          phase_nxt = PH_CK_LO;
        end
        PH_CK_LO: begin
          emit                   = 1'b1;
          res_nxt.item_kind      = KIND_END;
          res_nxt.data_byte      = 8'd0;
          res_nxt.byte_index     = 6'd0;
          res_nxt.packet_type    = held_type_r;
          res_nxt.reg_address    = held_addr_r;
          res_nxt.payload_length = exp_len_r;
          res_nxt.status         = (rx_sum != sum_r) ? STATUS_MISMATCH : STATUS_GOOD;
          res_nxt.computed_sum   = sum_r;
          phase_nxt              = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
    if (res_valid_r && !res_ready) begin
      res_valid_nxt = 1'b1;
    end else begin
      res_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      held_type_r <= 8'd0;
      held_addr_r <= 8'd0;
      exp_len_r   <= 6'd0;
      taken_r     <= 6'd0;
      sum_r       <= 16'd0;
      ck_hi_r     <= 8'd0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      held_type_r <= held_type_nxt;
      held_addr_r <= held_addr_nxt;
      exp_len_r   <= exp_len_nxt;
      taken_r     <= taken_nxt;
      sum_r       <= sum_nxt;
      ck_hi_r     <= ck_hi_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_r;

endmodule

[design/spd_out_buf.sv]
// Output register with a skid stage, so the ready toward the core is registered.
module spd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spd_pkg::spd_result_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spd_pkg::spd_result_t out_data
);
  import spd_pkg::*;

  logic        out_valid_r;
  logic        skid_valid_r;
  spd_result_t out_r;
  spd_result_t skid_r;
  logic        push;
  logic        pop;

  assign in_ready = !skid_valid_r;
  assign push     = in_valid && !skid_valid_r;
  assign pop      = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          if (push) begin
            out_r <= in_data;
          end
          out_valid_r <= push;
        end
      end else if (push) begin
        skid_r       <= in_data;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[design/sensor_packet_deframer.sv]
// Top level of the sensor packet deframer with its 16-bit additive checksum check.
//
// The deframer takes one received byte per item and accepts a byte in every
// cycle while the result side keeps draining. It hunts for the header "snp",
// then reads a packet-type byte and a register-address byte; the type byte
// sets the payload length (0, 4, or 4 bytes per register for a batch of up
// to 15 registers). Each payload byte leaves as a data item together with its
// index, the type, the address, the decoded length and the running sum that
// includes it. After the two big-endian checksum bytes an end item reports
// whether they match the 16-bit wrapping sum of header, type, address and
// payload bytes; on either outcome the hunt restarts with the next byte.
// Header, type, address and checksum-high bytes produce no item. A result
// passes from the framing state machine's result register to the output
// register, through the skid register while the output register is full.
// A two-entry output stage (output register plus skid register)
// lets the deframer take new bytes while a finished item waits, so input
// ready drops only when both entries and the result register are full.
module sensor_packet_deframer (
  input  logic clk,
  input  logic rst_n,
  spd_in_if.sink    in_ch,
  spd_out_if.source out_ch
);
  import spd_pkg::*;

  logic        res_valid;
  logic        res_ready;
  spd_result_t res_data;
  spd_result_t out_data;

  // Framing state machine and checksum adder; results land in its register.
  spd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.rx_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // Output register and skid entry decouple the result side from the core.
  spd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_data   (res_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.item_kind      = out_data.item_kind;
  assign out_ch.data_byte      = out_data.data_byte;
  assign out_ch.byte_index     = out_data.byte_index;
  assign out_ch.packet_type    = out_data.packet_type;
  assign out_ch.reg_address    = out_data.reg_address;
  assign out_ch.payload_length = out_data.payload_length;
  assign out_ch.status         = out_data.status;
  assign out_ch.computed_sum   = out_data.computed_sum;

endmodule
